// ===== src/fpuc_pkg.sv =====
// Package for the flow pulse usage cycle counter: payload structs, event
// kinds, register indexes, reset values and fixed limits.
// No dependencies.
package fpuc_pkg;

  // Event kinds carried by an input transfer
  typedef enum logic [1:0] {
    KIND_PULSE  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_CHECK  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_GAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_THRESH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_THRESH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MIN    = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0] PULSES_PER_GAL_RST = 16'd1;
  localparam logic [15:0] FIRST_THRESH_RST   = 16'd2;
  localparam logic [15:0] SECOND_THRESH_RST  = 16'd2;
  localparam logic [7:0]  TIMEOUT_MIN_RST    = 8'd1;

  // Arming and idle-minute limits
  localparam logic [15:0] ARM_MIN_RATE = 16'd10;
  localparam logic [7:0]  ARM_MAX_IDLE = 8'd10;
  localparam logic [7:0]  IDLE_WRAP_AT = 8'd75;
  localparam logic [7:0]  IDLE_WRAP_TO = 8'd15;

  typedef struct packed {
    kind_t kind;
    logic  signal_high;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rate_out;
    logic [31:0] total_out;
    logic        active_out;
    logic        heartbeat;
    logic        thresh_hit;
    logic [15:0] cycles_out;
    logic        save_strobe;
  } out_item_t;

endpackage

// ===== src/flow_pulse_usage_cycle_counter.sv =====
// Top level of the flow pulse usage cycle counter: input register, event
// update of the meter counters and a registered result stage.
// Depends on fpuc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one event per transfer:
//   a pulse edge, a one-second tick or a check. Every input transfer yields
//   exactly one result transfer on out_valid/out_ready/out_data, reporting
//   the meter state after that event (rate, total, active, heartbeat,
//   threshold flag, usage cycles and a save strobe for a counted cycle).
//   Configuration goes through cfg_we/cfg_index/cfg_wdata, one register
//   per cycle, written by the user only while the block is idle; unchecked.
// Flow:
//   An event taken from the input channel sits in the input register, is
//   applied to the counters as its result is loaded into the result
//   register, and is offered from there until the receiver takes it. One
//   event per cycle is sustained while out_ready stays high.
// Reset (rst_n low, synchronous): counters clear, idle seconds start at 15,
//   registers take their reset values and both channels empty.
// Stall: while out_ready is low the result holds; one more event waits in
//   the input register, after which in_ready drops.
module flow_pulse_usage_cycle_counter
  import fpuc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [15:0] ppg_r, thresh1_r, thresh2_r;
  logic [7:0]  timeout_r;
  // Thresholds scaled to pulses, straight from the configuration
  logic [31:0] limit1, limit2;

  // Pipeline control
  logic      in_valid_r, out_valid_r;
  in_item_t  in_item_r;
  out_item_t out_item_r, out_item_nxt;
  logic      advance;

  // Meter state
  logic [15:0] pulse_count_r, pulse_count_nxt;
  logic [15:0] rate_r, rate_nxt;
  logic [31:0] total_r, total_nxt;
  logic [7:0]  idle_sec_r, idle_sec_nxt;
  logic [7:0]  idle_min_r, idle_min_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] cycles_r, cycles_nxt;
  logic        active_r, active_nxt;
  logic        toggle_r, toggle_nxt;
  logic        met_r, met_nxt;
  logic        save;

  logic [32:0] total_sum;
  logic [7:0]  idle_min_chk;
  logic        armed_chk;

  // Move the held event into the result stage when the result slot is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Configuration writes; all four indexes name a register, so the default arm is unused
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppg_r     <= PULSES_PER_GAL_RST;
      thresh1_r <= FIRST_THRESH_RST;
      thresh2_r <= SECOND_THRESH_RST;
      timeout_r <= TIMEOUT_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSES_PER_GAL: ppg_r     <= cfg_wdata;
        REG_FIRST_THRESH:   thresh1_r <= cfg_wdata;
        REG_SECOND_THRESH:  thresh2_r <= cfg_wdata;
        REG_TIMEOUT_MIN:    timeout_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Scale thresholds by the K factor; 16 by 16 products fit in 32 bits
  assign limit1 = {16'd0, ppg_r} * {16'd0, thresh1_r};
  assign limit2 = {16'd0, ppg_r} * {16'd0, thresh2_r};

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  assign total_sum = {1'b0, total_r} + {17'd0, pulse_count_r};

  // Event update
  always_comb begin
    pulse_count_nxt = pulse_count_r;
    rate_nxt        = rate_r;
    total_nxt       = total_r;
    idle_sec_nxt    = idle_sec_r;
    idle_min_nxt    = idle_min_r;
    armed_nxt       = armed_r;
    cycles_nxt      = cycles_r;
    active_nxt      = active_r;
    toggle_nxt      = toggle_r;
    met_nxt         = met_r;
    save            = 1'b0;
    idle_min_chk    = idle_min_r;
    armed_chk       = armed_r;

    case (in_item_r.kind)
      KIND_PULSE: begin
        if (in_item_r.signal_high && (pulse_count_r != 16'hFFFF)) begin
          pulse_count_nxt = pulse_count_r + 16'd1;
        end
      end
      KIND_TICK: begin
        // Latch the rate, add it to the total and track activity
        rate_nxt        = pulse_count_r;
        toggle_nxt      = !toggle_r;
        pulse_count_nxt = '0;
        if (pulse_count_r != 16'd0) begin
          total_nxt    = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
          idle_sec_nxt = '0;
          active_nxt   = 1'b1;
        end else begin
          if (idle_sec_r != 8'hFF) idle_sec_nxt = idle_sec_r + 8'd1;
          active_nxt = 1'b0;
        end
      end
      KIND_CHECK: begin
        met_nxt = (total_r >= limit1) || (total_r >= limit2);
        // Arm on strong flow, else roll idle seconds into a minute
        if ((idle_sec_r <= ARM_MAX_IDLE) && (rate_r >= ARM_MIN_RATE)) begin
          idle_min_chk = '0;
          armed_chk    = 1'b1;
        end else if (idle_sec_r >= IDLE_WRAP_AT) begin
          idle_sec_nxt = IDLE_WRAP_TO;
          if (idle_min_r != 8'hFF) idle_min_chk = idle_min_r + 8'd1;
        end
        idle_min_nxt = idle_min_chk;
        armed_nxt    = armed_chk;
        // Count the cycle once idle long enough
        if ((idle_min_chk >= timeout_r) && armed_chk) begin
          armed_nxt    = 1'b0;
          idle_min_nxt = '0;
          save         = 1'b1;
          if (cycles_r != 16'hFFFF) cycles_nxt = cycles_r + 16'd1;
        end
      end
      default: ;
    endcase

    out_item_nxt.rate_out    = rate_nxt;
    out_item_nxt.total_out   = total_nxt;
    out_item_nxt.active_out  = active_nxt;
    out_item_nxt.heartbeat   = toggle_nxt;
    out_item_nxt.thresh_hit  = met_nxt;
    out_item_nxt.cycles_out  = cycles_nxt;
    out_item_nxt.save_strobe = save;
  end

  // Meter state advances only with a transfer into the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r <= '0;
      rate_r        <= '0;
      total_r       <= '0;
      idle_sec_r    <= IDLE_WRAP_TO;
      idle_min_r    <= '0;
      armed_r       <= 1'b0;
      cycles_r      <= '0;
      active_r      <= 1'b0;
      toggle_r      <= 1'b0;
      met_r         <= 1'b0;
    end else if (advance) begin
      pulse_count_r <= pulse_count_nxt;
      rate_r        <= rate_nxt;
      total_r       <= total_nxt;
      idle_sec_r    <= idle_sec_nxt;
      idle_min_r    <= idle_min_nxt;
      armed_r       <= armed_nxt;
      cycles_r      <= cycles_nxt;
      active_r      <= active_nxt;
      toggle_r      <= toggle_nxt;
      met_r         <= met_nxt;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
